>>> hdl/fhl_pkg.sv
`default_nettype none
package fhl_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int MAX_STEPS = 64;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int BUF_AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  localparam int COLUMN_W = 10;
  localparam int ROW_W = 15;
  localparam int CW = 16;
  localparam int YW = 16;
  localparam int EW = 18;
  localparam int MW = 15;
  localparam int HZ_W = 16;
  localparam int BUF_W = COLUMN_W + ROW_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [9:0] RESET_CENTER = 10'd512;
  localparam logic [10:0] RESET_WIDTH = 11'd1024;
  localparam logic [13:0] RESET_HEIGHT = 14'd768;

  typedef struct packed {
    logic in_ready;
    logic fetch;
    logic zero;
    logic step;
    logic clr_step;
    logic out_load;
  } fhl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic act;
    logic col_on;
    logic zero_len;
    logic col_move;
    logic step_end;
    logic clr_done;
    logic drain_done;
    logic out_fire;
  } fhl_stat_t;

endpackage
`default_nettype wire

>>> hdl/fhl_in_if.sv
`default_nettype none
interface fhl_in_if;
  logic valid;
  logic ready;
  logic action;
  logic signed [14:0] start_x;
  logic signed [14:0] start_y;
  logic signed [14:0] end_x;
  logic signed [14:0] end_y;

  modport source(output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

>>> hdl/fhl_out_if.sv
`default_nettype none
interface fhl_out_if;
  logic valid;
  logic ready;
  logic [9:0] column;
  logic signed [14:0] row;
  logic plotted;
  logic last;
  logic truncated;

  modport source(output valid, column, row, plotted, last, truncated, input ready);
  modport sink(input valid, column, row, plotted, last, truncated, output ready);
endinterface
`default_nettype wire

>>> hdl/fhl_ram.sv
`default_nettype none
module fhl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/fhl_datapath.sv
`default_nettype none
module fhl_datapath import fhl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  fhl_in_if.sink                     in_ch,
  fhl_out_if.source                  out_ch,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire fhl_cmd_t              cmd,
  output fhl_stat_t                  stat
);

  logic [9:0] center;
  logic [10:0] width;
  logic [13:0] height;
  logic [13:0] clr_h;
  logic [COL_W-1:0] clr_cnt;

  logic act, swapped, x_nz, x_neg, y_nz, y_neg, trunc_en, zero_len, left;
  logic signed [CW-1:0] col;
  logic signed [YW-1:0] yc, hu, hl, ymax, ymin;
  logic signed [EW-1:0] e;
  logic [MW-1:0] mj, mn;
  logic [STEP_W-1:0] steps, i, n, k;

  logic [9:0] column;
  logic signed [14:0] row;
  logic plotted, last, truncated, out_valid;

  logic in_fire;
  logic signed [15:0] dx, dy;
  logic [MW-1:0] adx, ady, mjv, mnv;
  logic swp;
  logic signed [CW-1:0] col0;

  logic above, below, e_pos, col_move, left_n, last_step;
  logic signed [YW-1:0] ymax_n, ymin_n, y_step, yc_n, zu, zl;
  logic signed [EW-1:0] e_n, mj2, mn2;
  logic signed [CW-1:0] col_n;

  logic hz_we;
  logic [COL_W-1:0] hz_waddr;
  logic [2*HZ_W-1:0] hz_wdata, hz_rdata;
  logic buf_we;
  logic [BUF_W-1:0] buf_wdata, buf_rdata;

  function automatic logic on_screen(input logic signed [CW-1:0] c, input logic [10:0] w);
    on_screen = !c[CW-1] && (c[CW-2:0] < (CW-1)'(w)) && (c[CW-2:0] < (CW-1)'(MAX_COLUMNS));
  endfunction

  assign in_fire = in_ch.valid && cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;

  always_comb begin
    dx = {in_ch.end_x[14], in_ch.end_x} - {in_ch.start_x[14], in_ch.start_x};
    dy = {in_ch.end_y[14], in_ch.end_y} - {in_ch.start_y[14], in_ch.start_y};
    adx = dx[15] ? MW'(-dx) : dx[MW-1:0];
    ady = dy[15] ? MW'(-dy) : dy[MW-1:0];
    swp = ady > adx;
    mjv = swp ? ady : adx;
    mnv = swp ? adx : ady;
    col0 = {in_ch.start_x[14], in_ch.start_x} + {6'b0, center};
  end

  always_comb begin
    above = yc >= hu;
    below = yc <= hl;
    ymax_n = (above && yc >= ymax) ? yc : ymax;
    ymin_n = (below && yc <= ymin) ? yc : ymin;
    e_pos = !e[EW-1] && (e != '0);
    mj2 = $signed({2'b0, mj, 1'b0});
    mn2 = $signed({2'b0, mn, 1'b0});
    e_n = e + mn2 - (e_pos ? mj2 : '0);
    col_move = swapped ? e_pos : 1'b1;
    col_n = x_nz ? (x_neg ? col - 16'sd1 : col + 16'sd1) : col;
    y_step = y_nz ? (y_neg ? yc - 16'sd1 : yc + 16'sd1) : yc;
    yc_n = (swapped || e_pos) ? y_step : yc;
    left_n = col_move && !on_screen(col_n, width);
    last_step = STEP_W'(i + 1'b1) == steps;
    zu = (yc > hu) ? yc : hu;
    zl = (yc < hl) ? yc : hl;
  end

  always_comb begin
    hz_we = 1'b0;
    hz_waddr = col[COL_W-1:0];
    hz_wdata = {ymax_n, ymin_n};
    priority if (cmd.clr_step) begin
      hz_we = 1'b1;
      hz_waddr = clr_cnt;
      hz_wdata = {HZ_W'(-$signed({2'b0, clr_h})), {2'b0, clr_h}};
    end else if (cmd.zero) begin
      hz_we = 1'b1;
      hz_wdata = {zu, zl};
    end else if (cmd.step) begin
      hz_we = col_move;
    end
    buf_we = cmd.zero || cmd.step;
    buf_wdata = {col[COLUMN_W-1:0], yc[ROW_W-1:0], cmd.zero || above || below};
  end

  fhl_ram #(.WIDTH(2 * HZ_W), .DEPTH(MAX_COLUMNS)) u_horizon (
    .clk(clk), .we(hz_we), .waddr(hz_waddr), .wdata(hz_wdata),
    .raddr(col[COL_W-1:0]), .rdata(hz_rdata)
  );

  fhl_ram #(.WIDTH(BUF_W), .DEPTH(MAX_STEPS)) u_results (
    .clk(clk), .we(buf_we), .waddr(n[BUF_AW-1:0]), .wdata(buf_wdata),
    .raddr(k[BUF_AW-1:0]), .rdata(buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= RESET_CENTER;
      width <= RESET_WIDTH;
      height <= RESET_HEIGHT;
      clr_h <= RESET_HEIGHT;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      n <= '0;
      k <= '0;
      i <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CENTER: center <= cfg_data[9:0];
          CFG_WIDTH: width <= cfg_data[10:0];
          CFG_HEIGHT: height <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        clr_h <= height;
        clr_cnt <= '0;
        n <= '0;
        k <= '0;
        i <= '0;
      end
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.zero) n <= STEP_W'(1);
      if (cmd.step) begin
        n <= n + 1'b1;
        i <= i + 1'b1;
      end
      if (cmd.out_load) begin
        k <= k + 1'b1;
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act <= in_ch.action;
      swapped <= swp;
      mj <= mjv;
      mn <= mnv;
      x_nz <= dx != '0;
      x_neg <= dx[15];
      y_nz <= dy != '0;
      y_neg <= dy[15];
      zero_len <= mjv == '0;
      trunc_en <= mjv > MW'(MAX_STEPS);
      steps <= (mjv > MW'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : STEP_W'(mjv);
      e <= $signed({2'b0, mnv, 1'b0}) - $signed({3'b0, mjv});
      col <= col0;
      yc <= {in_ch.start_y[14], in_ch.start_y};
      left <= 1'b0;
    end
    if (cmd.fetch) begin
      hu <= hz_rdata[2*HZ_W-1:HZ_W];
      hl <= hz_rdata[HZ_W-1:0];
      ymax <= hz_rdata[2*HZ_W-1:HZ_W];
      ymin <= hz_rdata[HZ_W-1:0];
    end
    if (cmd.step) begin
      e <= e_n;
      yc <= yc_n;
      ymax <= ymax_n;
      ymin <= ymin_n;
      left <= left_n;
      if (col_move) col <= col_n;
    end
    if (cmd.out_load) begin
      column <= buf_rdata[BUF_W-1:ROW_W+1];
      row <= buf_rdata[ROW_W:1];
      plotted <= buf_rdata[0];
      last <= STEP_W'(k + 1'b1) == n;
      truncated <= trunc_en && !left;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.column = column;
  assign out_ch.row = row;
  assign out_ch.plotted = plotted;
  assign out_ch.last = last;
  assign out_ch.truncated = truncated;

  always_comb begin
    stat.in_valid = in_ch.valid;
    stat.act = act;
    stat.col_on = on_screen(col, width);
    stat.zero_len = zero_len;
    stat.col_move = col_move;
    stat.step_end = left_n || last_step;
    stat.clr_done = clr_cnt == COL_W'(MAX_COLUMNS - 1);
    stat.drain_done = k == n;
    stat.out_fire = out_valid && out_ch.ready;
  end

endmodule
`default_nettype wire

>>> hdl/fhl_ctrl.sv
`default_nettype none
module fhl_ctrl import fhl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fhl_stat_t stat,
  output fhl_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_ZWR = 4'd3;
  localparam logic [3:0] S_STEP = 4'd4;
  localparam logic [3:0] S_CLEAR = 4'd5;
  localparam logic [3:0] S_DRD = 4'd6;
  localparam logic [3:0] S_DLD = 4'd7;
  localparam logic [3:0] S_DSHOW = 4'd8;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        priority if (!stat.act) state_next = S_CLEAR;
        else if (!stat.col_on) state_next = S_IDLE;
        else state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = stat.zero_len ? S_ZWR : S_STEP;
      end
      S_ZWR: begin
        cmd.zero = 1'b1;
        state_next = S_DRD;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        priority if (stat.step_end) state_next = S_DRD;
        else if (stat.col_move) state_next = S_SETUP;
        else state_next = S_STEP;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_DRD: state_next = S_DLD;
      S_DLD: begin
        cmd.out_load = 1'b1;
        state_next = S_DSHOW;
      end
      S_DSHOW: begin
        if (stat.out_fire) state_next = stat.drain_done ? S_IDLE : S_DLD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/floating_horizon_line_raster.sv
// A draw walks its segment one step a cycle, but goes back through setup and a horizon fetch
//   at each column change; its buffered results are then handed out one by one on out_ch.
// One segment at a time: a new request is taken only in idle, after the last one is done.
// A clear resets all 1024 horizon columns, one column per cycle.
// Reset (rst, synchronous) loads the register defaults and runs the same clear pass;
//   no request is taken until it ends.
`default_nettype none
module floating_horizon_line_raster import fhl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  fhl_in_if.sink                     in_ch,
  fhl_out_if.source                  out_ch,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  fhl_cmd_t cmd;
  fhl_stat_t stat;

  fhl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .cmd(cmd)
  );

  fhl_datapath u_datapath (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat)
  );

endmodule
`default_nettype wire
